// ----- rtl/core/vertex_stream_bounding_box_unit_defines.svh -----
// Assertion macros for the vertex stream bounding box unit.
// Used by rtl/core modules; expects aclk and aresetn in the including scope.
`ifndef VERTEX_STREAM_BOUNDING_BOX_UNIT_DEFINES_SVH
`define VERTEX_STREAM_BOUNDING_BOX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VBB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define VBB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VBB_ASSERT_IMP(label, ante, cons, msg)
`define VBB_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/vbb_pkg.sv -----
// Shared types and constants of the vertex stream bounding box unit.
// No dependencies.
`timescale 1ns / 1ps
package vbb_pkg;

    localparam int FIELD_W         = 32;
    localparam int COEF_W          = 32;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_AXES        = 3;
    localparam int NUM_TERMS       = 4;
    localparam int NUM_MAT_REGS    = 6;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH     = 8;   // power of two
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W           = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_USE_TRANSFORM = 3'd0,
        REG_ROW_X_FIRST   = 3'd1,
        REG_ROW_X_SECOND  = 3'd2,
        REG_ROW_Y_FIRST   = 3'd3,
        REG_ROW_Y_SECOND  = 3'd4,
        REG_ROW_Z_FIRST   = 3'd5,
        REG_ROW_Z_SECOND  = 3'd6
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] MAT_RESET [NUM_MAT_REGS] = '{
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_LAST   = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] pos_w;
        logic                      last_vertex;
        logic                      empty_set;
    } s_payload_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] min_x;
        logic signed [FIELD_W-1:0] min_y;
        logic signed [FIELD_W-1:0] min_z;
        logic signed [FIELD_W-1:0] max_x;
        logic signed [FIELD_W-1:0] max_y;
        logic signed [FIELD_W-1:0] max_z;
    } m_payload_t;

    // Classified vertex as it sits in the queue; coords sign-extended
    typedef struct packed {
        kind_t                              kind;
        logic [NUM_AXES-1:0][FIELD_W-1:0]   coord;
    } item_t;

endpackage

// ----- rtl/core/vbb_front.sv -----
// Front end: config registers, input classification and transform pipeline.
// Depends on vbb_pkg; pushes finished items into vbb_fifo.
`timescale 1ns / 1ps
module vbb_front #(
    parameter int COORD_WIDTH = vbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [vbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vbb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vbb_pkg::s_payload_t                 s_data,
    input  logic [vbb_pkg::CNT_W-1:0]           queue_count,
    output logic                                push_valid,
    output vbb_pkg::item_t                      push_item
);

    localparam int PROD_W = vbb_pkg::COEF_W + COORD_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int STAGES = 4;
    localparam int INFL_W = $clog2(STAGES + 1);
    localparam int OCC_W  = vbb_pkg::CNT_W + 1;
    localparam int NA     = vbb_pkg::NUM_AXES;
    localparam int NT     = vbb_pkg::NUM_TERMS;
    localparam int CW     = vbb_pkg::COEF_W;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic                               use_transform_reg;
    logic [vbb_pkg::CFG_DATA_W-1:0]     coef_pair_reg [vbb_pkg::NUM_MAT_REGS];

    logic                               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    vbb_pkg::kind_t                     kind_in;
    vbb_pkg::kind_t                     a_kind_reg, b_kind_reg, c_kind_reg, d_kind_reg;
    logic signed [COORD_WIDTH-1:0]      a_pos_reg [NT];
    logic signed [COORD_WIDTH-1:0]      b_pos_reg [NA];
    logic signed [COORD_WIDTH-1:0]      c_pos_reg [NA];
    logic signed [COORD_WIDTH-1:0]      d_pos_reg [NA];
    logic signed [PROD_W-1:0]           b_prod_reg [NA][NT];
    logic signed [PAIR_W-1:0]           c_pair_reg [NA][2];
    logic signed [SUM_W-1:0]            d_sum_reg [NA];

    logic signed [SUM_W-1:0]            shifted [NA];
    logic signed [COORD_WIDTH-1:0]      sat_val [NA];
    logic [INFL_W-1:0]                  inflight;
    logic [OCC_W-1:0]                   occupancy;
    logic                               s_accept;

    // ---- configuration registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_transform_reg <= 1'b0;
            for (int i = 0; i < vbb_pkg::NUM_MAT_REGS; i++) begin
                coef_pair_reg[i] <= vbb_pkg::MAT_RESET[i];
            end
        end else if (cfg_we) begin
            case (vbb_pkg::cfg_reg_t'(cfg_index))
                vbb_pkg::REG_USE_TRANSFORM: use_transform_reg <= cfg_wdata[0];
                vbb_pkg::REG_ROW_X_FIRST:   coef_pair_reg[0] <= cfg_wdata;
                vbb_pkg::REG_ROW_X_SECOND:  coef_pair_reg[1] <= cfg_wdata;
                vbb_pkg::REG_ROW_Y_FIRST:   coef_pair_reg[2] <= cfg_wdata;
                vbb_pkg::REG_ROW_Y_SECOND:  coef_pair_reg[3] <= cfg_wdata;
                vbb_pkg::REG_ROW_Z_FIRST:   coef_pair_reg[4] <= cfg_wdata;
                vbb_pkg::REG_ROW_Z_SECOND:  coef_pair_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- admission: every accepted item has a queue slot reserved ----
    assign inflight  = INFL_W'(a_valid_reg) + INFL_W'(b_valid_reg)
                     + INFL_W'(c_valid_reg) + INFL_W'(d_valid_reg);
    assign occupancy = OCC_W'(queue_count) + OCC_W'(inflight);
    assign s_ready   = (occupancy < OCC_W'(vbb_pkg::QUEUE_DEPTH));
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        if (s_data.empty_set) begin
            kind_in = vbb_pkg::KIND_EMPTY;
        end else if (s_data.last_vertex) begin
            kind_in = vbb_pkg::KIND_LAST;
        end else begin
            kind_in = vbb_pkg::KIND_VERTEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // ---- datapath: register, multiply, pair add, final add ----
    always_ff @(posedge aclk) begin
        a_kind_reg   <= kind_in;
        a_pos_reg[0] <= COORD_WIDTH'(s_data.pos_x);
        a_pos_reg[1] <= COORD_WIDTH'(s_data.pos_y);
        a_pos_reg[2] <= COORD_WIDTH'(s_data.pos_z);
        a_pos_reg[3] <= COORD_WIDTH'(s_data.pos_w);

        b_kind_reg <= a_kind_reg;
        c_kind_reg <= b_kind_reg;
        d_kind_reg <= c_kind_reg;
        for (int a = 0; a < NA; a++) begin
            b_pos_reg[a] <= a_pos_reg[a];
            c_pos_reg[a] <= b_pos_reg[a];
            d_pos_reg[a] <= c_pos_reg[a];
            for (int t = 0; t < NT; t++) begin
                // coefficient m[a][t]: pair register a*2 + t/2, word t&1
                b_prod_reg[a][t] <=
                    PROD_W'($signed(coef_pair_reg[a * 2 + (t >> 1)][(t & 1) * CW +: CW]))
                    * PROD_W'(a_pos_reg[t]);
            end
            c_pair_reg[a][0] <= PAIR_W'(b_prod_reg[a][0]) + PAIR_W'(b_prod_reg[a][1]);
            c_pair_reg[a][1] <= PAIR_W'(b_prod_reg[a][2]) + PAIR_W'(b_prod_reg[a][3]);
            d_sum_reg[a]     <= SUM_W'(c_pair_reg[a][0]) + SUM_W'(c_pair_reg[a][1]);
        end
    end

    // floor shift, saturate, pick raw or transformed
    always_comb begin
        push_item.kind = d_kind_reg;
        for (int a = 0; a < NA; a++) begin
            shifted[a] = d_sum_reg[a] >>> FRAC_BITS;
            if (shifted[a] > SAT_HI) begin
                sat_val[a] = COORD_WIDTH'(SAT_HI);
            end else if (shifted[a] < SAT_LO) begin
                sat_val[a] = COORD_WIDTH'(SAT_LO);
            end else begin
                sat_val[a] = COORD_WIDTH'(shifted[a]);
            end
            if (use_transform_reg) begin
                push_item.coord[a] = vbb_pkg::FIELD_W'(sat_val[a]);
            end else begin
                push_item.coord[a] = vbb_pkg::FIELD_W'(d_pos_reg[a]);
            end
        end
    end

    assign push_valid = d_valid_reg;

endmodule

// ----- rtl/core/vbb_fifo.sv -----
// Short queue between the front end and the box update.
// Depends on vbb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_stream_bounding_box_unit_defines.svh"
module vbb_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  vbb_pkg::item_t              push_item,
    input  logic                        pop,
    output logic                        head_valid,
    output vbb_pkg::item_t              head_item,
    output logic [vbb_pkg::CNT_W-1:0]   count
);

    vbb_pkg::item_t                     slot_reg [vbb_pkg::QUEUE_DEPTH];
    logic [vbb_pkg::PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [vbb_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                               full;

    assign full       = (count_reg == vbb_pkg::CNT_W'(vbb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + vbb_pkg::CNT_W'(1);
        end else if (!push_valid && pop) begin
            count_next = count_reg - vbb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + vbb_pkg::PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + vbb_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // front end reserves a slot per accepted item, so it never pushes into a full queue
    `VBB_ASSERT_IMP(a_no_overflow, push_valid, !full, "queue overflow")

endmodule

// ----- rtl/core/vbb_back.sv -----
// Back end: running per-axis min/max and the result output register.
// Depends on vbb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_stream_bounding_box_unit_defines.svh"
module vbb_back #(
    parameter int COORD_WIDTH = vbb_pkg::COORD_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  vbb_pkg::item_t          head_item,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output vbb_pkg::m_payload_t     m_data
);

    localparam int NA = vbb_pkg::NUM_AXES;
    localparam logic signed [COORD_WIDTH-1:0] BOX_HI = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] BOX_LO = ~BOX_HI;

    logic signed [COORD_WIDTH-1:0]  min_reg [NA];
    logic signed [COORD_WIDTH-1:0]  max_reg [NA];
    logic signed [COORD_WIDTH-1:0]  q      [NA];
    logic signed [COORD_WIDTH-1:0]  min_new [NA];
    logic signed [COORD_WIDTH-1:0]  max_new [NA];
    logic                           m_valid_reg, m_valid_next;
    vbb_pkg::m_payload_t            m_data_reg;
    logic                           has_result, out_free, emit;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            q[a]       = COORD_WIDTH'(head_item.coord[a]);
            min_new[a] = (q[a] < min_reg[a]) ? q[a] : min_reg[a];
            max_new[a] = (q[a] > max_reg[a]) ? q[a] : max_reg[a];
        end
    end

    assign has_result = (head_item.kind != vbb_pkg::KIND_VERTEX);
    assign out_free   = !m_valid_reg || m_ready;
    assign pop        = head_valid && (!has_result || out_free);
    assign emit       = pop && has_result;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int a = 0; a < NA; a++) begin
                min_reg[a] <= BOX_HI;
                max_reg[a] <= BOX_LO;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                case (head_item.kind)
                    vbb_pkg::KIND_VERTEX: begin
                        for (int a = 0; a < NA; a++) begin
                            min_reg[a] <= min_new[a];
                            max_reg[a] <= max_new[a];
                        end
                    end
                    vbb_pkg::KIND_LAST, vbb_pkg::KIND_EMPTY: begin
                        for (int a = 0; a < NA; a++) begin
                            min_reg[a] <= BOX_HI;
                            max_reg[a] <= BOX_LO;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (head_item.kind == vbb_pkg::KIND_LAST) begin
                m_data_reg.min_x <= vbb_pkg::FIELD_W'(min_new[0]);
                m_data_reg.min_y <= vbb_pkg::FIELD_W'(min_new[1]);
                m_data_reg.min_z <= vbb_pkg::FIELD_W'(min_new[2]);
                m_data_reg.max_x <= vbb_pkg::FIELD_W'(max_new[0]);
                m_data_reg.max_y <= vbb_pkg::FIELD_W'(max_new[1]);
                m_data_reg.max_z <= vbb_pkg::FIELD_W'(max_new[2]);
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `VBB_ASSERT_NXT(a_result_loaded, emit, m_valid_reg, "result lost on output")
    `VBB_ASSERT_NXT(a_box_cleared, emit, (min_reg[0] == BOX_HI) && (max_reg[2] == BOX_LO), "box not cleared after result")
    `VBB_ASSERT_IMP(a_pop_needs_slot, emit, out_free, "result popped while output held")

endmodule

// ----- rtl/core/vertex_stream_bounding_box_unit.sv -----
// Top level of the vertex stream bounding box unit.
// Depends on vbb_pkg, vbb_front, vbb_fifo and vbb_back.
`timescale 1ns / 1ps
// Computes the axis-aligned bounding box of a stream of vertex positions.
// One vertex transfer is taken per clock (s_valid/s_ready), with no gaps, as
// long as results are drained. Each vertex optionally goes through the top
// three rows of the configured 4x4 matrix: products are exact, summed, floor
// shifted by FRAC_BITS and saturated to COORD_WIDTH. The front pipeline is
// four stages (input register, twelve 32x32 multiplies, pair add, final add);
// saturation and the raw/transform select happen on the way into an 8-entry
// queue, and the back end updates the running min/max as each vertex is
// popped, which is the only recurrent loop. A vertex marked last_vertex
// produces one result transfer on m_valid/m_ready once it leaves the queue;
// an item with empty_set produces an all-zero box and discards the
// set collected so far. Either marker returns the box to its cleared state.
// The result sits in an output register, so a stalled m_ready does not stop
// input until the queue fills. Config registers are written through
// cfg_we/cfg_index/cfg_wdata and should only change while the unit is idle;
// index 0 is use_transform, 1..6 are the coefficient pairs, 7 is ignored.
module vertex_stream_bounding_box_unit #(
    parameter int COORD_WIDTH = vbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [vbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vbb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vbb_pkg::s_payload_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vbb_pkg::m_payload_t                 m_data
);

    // front to queue
    logic                           push_valid;
    vbb_pkg::item_t                 push_item;
    // queue to back
    logic                           head_valid;
    vbb_pkg::item_t                 head_item;
    logic                           pop;
    logic [vbb_pkg::CNT_W-1:0]      queue_count;

    // Front: config, classification (vertex / last / empty) and transform.
    // It only takes a transfer when a queue slot is free for it, so its
    // pipeline never stalls.
    vbb_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .queue_count (queue_count),
        .push_valid  (push_valid),
        .push_item   (push_item)
    );

    // Queue decouples the front pipeline from output backpressure.
    vbb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (queue_count)
    );

    // Back: running box and result register. Plain vertices always drain;
    // a result item waits only for the output register.
    vbb_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
